// File: hw/rtl/bqeq_pkg.sv
// Package for the biquad cascade equalizer: types, codes and fixed constants.
// Used by every module of the block; depends on nothing.
package bqeq_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 32;
    localparam int GAIN_W   = 16;
    localparam int IDX_W    = 5;
    localparam int ACC_W    = 66;
    localparam int PROD_W   = 64;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd32768;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    typedef enum logic [0:0] {
        REQ_SAMPLE = 1'b0,
        REQ_COEF   = 1'b1
    } t_req;

    typedef enum logic [0:0] {
        CFG_VOLUME_GAIN   = 1'b0,
        CFG_FILTER_ENABLE = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOAD,
        ST_MUL,
        ST_ACC,
        ST_SECT,
        ST_GAIN,
        ST_OUT
    } t_state;

    // Handshake between the sequencer and the serial multiplier.
    typedef struct packed {
        logic start;
    } t_mul_ctl;

    typedef struct packed {
        logic done;
    } t_mul_sts;

endpackage

// File: hw/rtl/bqeq_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-and-add.
// Depends on bqeq_pkg for the control struct types.
module bqeq_mul (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bqeq_pkg::t_mul_ctl       i_ctl,
    input  logic signed [31:0]       i_a,
    input  logic signed [31:0]       i_b,
    output bqeq_pkg::t_mul_sts       o_sts,
    output logic signed [63:0]       o_p
);
    import bqeq_pkg::*;

    logic [5:0]         r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic signed [63:0] r_acc, n_acc;
    logic signed [63:0] r_mcand, n_mcand;
    logic [31:0]        r_mplier, n_mplier;

    always_comb begin
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        if (i_ctl.start) begin
            n_cnt    = 6'd0;
            n_busy   = 1'b1;
            n_acc    = '0;
            n_mcand  = 64'(i_a);
            n_mplier = i_b;
        end else if (r_busy) begin
            // Two's complement: the top multiplier bit carries negative weight.
            if (r_mplier[0]) begin
                if (r_cnt == 6'd31) n_acc = r_acc - r_mcand;
                else                n_acc = r_acc + r_mcand;
            end
            n_mcand  = r_mcand <<< 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_sts.done = r_done;
    assign o_p        = r_acc;
endmodule

// File: hw/rtl/biquad_cascade_equalizer.sv
// Biquad cascade equalizer: NUM_SECTIONS Direct Form I sections, gain, clamp.
// Each filtered sample runs through every section in turn: a section loads its history,
// forms five products on the one bit-serial 32x32 multiplier and writes its history back;
// then the gain is applied. A new sample is taken only after the last result is loaded.
// Coefficient writes and passthrough samples are taken one per cycle while the block is
// idle and the output is free. After reset a clearing pass loads passthrough coefficients and zeroes history.
module biquad_cascade_equalizer #(
    parameter int NUM_SECTIONS   = 5,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_req_type,
    input  logic signed [15:0]   i_sample_in,
    input  logic [4:0]           i_coef_index,
    input  logic signed [31:0]   i_coef_value,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [15:0]   o_sample_out,
    output logic                 o_clipped,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import bqeq_pkg::*;

    localparam int NCOEF  = NUM_SECTIONS * 5;
    localparam int NHIST  = NUM_SECTIONS * 4;
    localparam int CW     = $clog2(NCOEF);
    localparam int HW     = $clog2(NHIST);
    localparam int SW     = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
    localparam int CLR_N  = (NCOEF > NHIST) ? NCOEF : NHIST;
    localparam int CLRW   = $clog2(CLR_N + 1);
    localparam int RSH    = COEF_FRAC_BITS - 2;
    localparam logic signed [31:0] COEF_ONE = 32'sd1 <<< COEF_FRAC_BITS;

    // Coefficient and history memories, one write and one registered read.
    logic signed [31:0] coef_mem [NCOEF];
    logic signed [31:0] hist_mem [NHIST];

    // Configuration registers.
    logic [GAIN_W-1:0] r_gain;
    logic              r_enable;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_VOLUME_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_FILTER_ENABLE: r_enable <= i_cfg_data[0];
                default:           r_enable <= r_enable;
            endcase
        end
    end

    // Sequencer state.
    t_state r_state, n_state;
    logic [CLRW-1:0]    r_clr;
    logic [SW-1:0]      r_sec;
    logic [2:0]         r_term;      // 0..4: b0,b1,b2,-a1,-a2
    logic signed [31:0] r_x;         // current section input
    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0] r_h [4];     // history of current section
    logic signed [31:0] r_coef_rd;
    logic signed [31:0] r_hist_rd;
    logic [2:0]         r_ld;        // load step within a section
    logic               r_out_valid;
    logic signed [15:0] r_out_sample;
    logic               r_out_clip;
    logic               r_busy;      // an item is in work
    logic [1:0]         r_pass;

    // Multiplier.
    t_mul_ctl           mul_ctl;
    t_mul_sts           mul_sts;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic               r_gain_phase;

    bqeq_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_sts   (mul_sts),
        .o_p     (mul_p)
    );

    // Operand selection: history term per step, gain from the gain start onward.
    always_comb begin
        mul_a = r_coef_rd;
        unique case (r_term)
            3'd0:    mul_b = r_x;
            3'd1:    mul_b = r_h[0];
            3'd2:    mul_b = r_h[1];
            3'd3:    mul_b = r_h[2];
            3'd4:    mul_b = r_h[3];
            default: mul_b = r_x;
        endcase
        if (r_gain_phase || r_state == ST_GAIN) begin
            mul_a = r_x;
            mul_b = (r_gain > GAIN_MAX) ? 32'(GAIN_MAX) : 32'(r_gain);
        end
    end

    // Rounded, saturated section output from the accumulator.
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [ACC_W-1:0] acc_shr;
    logic signed [31:0]      sect_y;
    always_comb begin
        acc_rnd = r_acc + (ACC_W'(1) <<< (RSH - 1));
        acc_shr = acc_rnd >>> RSH;
        if (acc_shr > ACC_W'(64'sh7FFF_FFFF))
            sect_y = 32'sh7FFF_FFFF;
        else if (acc_shr < -ACC_W'(64'sh8000_0000))
            sect_y = 32'sh8000_0000;
        else
            sect_y = acc_shr[31:0];
    end

    // Output scaling of p (Q41): clamp to +-1, else trunc(|p|*32767 >> 41).
    localparam logic signed [63:0] OUT_ONE = 64'sd1 <<< 41;
    logic [63:0] mag;
    logic [63:0] q_mag;
    logic        p_neg;
    always_comb begin
        p_neg = mul_p[63];
        mag   = p_neg ? 64'(-mul_p) : 64'(mul_p);
        // |p| <= 2^41 here, so |p|*32767 = (|p|<<15) - |p| fits in 57 bits.
        q_mag = ((mag << 15) - mag) >> 41;
    end

    wire accept_in  = i_valid && o_ready;
    wire out_free   = !r_out_valid || i_ready;
    // A result word is loaded by a disabled passthrough or at the end of filtering.
    wire out_load   = (r_state == ST_IDLE && accept_in && i_req_type == REQ_SAMPLE
                       && !r_enable) || (r_state == ST_OUT && out_free);
    wire [CW-1:0] sec_base5 = CW'(r_sec) * CW'(5);
    wire [HW-1:0] sec_base4 = HW'(r_sec) * HW'(4);

    assign o_ready = (r_state == ST_IDLE) && !r_busy && out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == CLRW'(CLR_N - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (accept_in && i_req_type == REQ_SAMPLE && r_enable)
                          n_state = ST_LOAD;
            ST_LOAD:  if (r_ld == 3'd6) n_state = ST_MUL;
            ST_MUL:   n_state = ST_ACC;
            ST_ACC:   if (mul_sts.done) begin
                          if (r_gain_phase)      n_state = ST_OUT;
                          else if (r_term == 3'd4) n_state = ST_SECT;
                          else                   n_state = ST_MUL;
                      end
            ST_SECT:  n_state = (r_pass == 2'd3) ?
                          ((r_sec == SW'(NUM_SECTIONS - 1)) ? ST_GAIN : ST_LOAD) : ST_SECT;
            ST_GAIN:  n_state = ST_ACC;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer toward the multiplier.
    always_comb begin
        mul_ctl.start = (r_state == ST_MUL) || (r_state == ST_GAIN);
    end

    // Memory addresses: the coefficient for the next term is read in the cycle
    // that ends the current product, so it is in place when the next multiply
    // starts. Load steps 0..3 read the history; the data arrives in the next cycle.
    logic [CW-1:0] coef_addr;
    logic [HW-1:0] hist_addr;
    logic [2:0]    term_rd;
    always_comb begin
        term_rd   = (r_state == ST_ACC && mul_sts.done && r_term != 3'd4) ?
                    r_term + 3'd1 : r_term;
        coef_addr = sec_base5 + CW'(term_rd);
        hist_addr = sec_base4 + HW'(r_ld[1:0]);
    end

    // During the clearing pass, marks the b0 slot of each section.
    logic clr_b0;
    always_comb begin
        clr_b0 = 1'b0;
        for (int s = 0; s < NUM_SECTIONS; s++) begin
            if (r_clr == CLRW'(s * 5)) clr_b0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        // Coefficient memory: clear pass, software writes, sequencer reads.
        if (r_state == ST_CLEAR) begin
            if (r_clr < CLRW'(NCOEF))
                coef_mem[r_clr[CW-1:0]] <= clr_b0 ? COEF_ONE : '0;
        end else if (accept_in && i_req_type == REQ_COEF
                     && 32'(i_coef_index) < 32'(NCOEF)) begin
            coef_mem[i_coef_index[CW-1:0]] <= i_coef_value;
        end
        r_coef_rd <= coef_mem[coef_addr];

        // History memory: clear pass, write-back of a section, reads.
        if (r_state == ST_CLEAR) begin
            if (r_clr < CLRW'(NHIST))
                hist_mem[r_clr[HW-1:0]] <= '0;
        end else if (r_state == ST_SECT) begin
            unique case (r_pass)
                2'd0: hist_mem[sec_base4]        <= r_x;
                2'd1: hist_mem[sec_base4 + HW'(1)] <= r_h[0];
                2'd2: hist_mem[sec_base4 + HW'(2)] <= sect_y;
                default: hist_mem[sec_base4 + HW'(3)] <= r_h[2];
            endcase
        end
        r_hist_rd <= hist_mem[hist_addr];
    end

    // Datapath and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_busy       <= 1'b0;
            r_sec        <= '0;
            r_term       <= '0;
            r_ld         <= '0;
            r_pass       <= '0;
            r_gain_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load)                    r_out_valid <= 1'b1;
            else if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_CLEAR: r_clr <= r_clr + CLRW'(1);
                ST_IDLE: begin
                    if (accept_in && i_req_type == REQ_SAMPLE) begin
                        if (r_enable) begin
                            r_busy <= 1'b1;
                            r_sec  <= '0;
                            r_ld   <= '0;
                            r_term <= '0;
                            r_x    <= 32'(i_sample_in) <<< 12;
                        end else begin
                            r_out_sample <= i_sample_in;
                            r_out_clip   <= 1'b0;
                        end
                    end
                end
                ST_LOAD: begin
                    // Step k issues history address k; its data lands at k+1.
                    if (r_ld >= 3'd1 && r_ld <= 3'd4) r_h[r_ld[1:0] - 2'd1] <= r_hist_rd;
                    r_ld   <= r_ld + 3'd1;
                    r_acc  <= '0;
                    r_term <= '0;
                end
                ST_MUL: ;
                ST_ACC: begin
                    if (mul_sts.done && !r_gain_phase) begin
                        // Product shifted right by two (floor), then summed.
                        r_acc  <= r_acc + ACC_W'(mul_p >>> 2);
                        r_term <= r_term + 3'd1;
                    end
                end
                ST_SECT: begin
                    r_pass <= r_pass + 2'd1;
                    if (r_pass == 2'd3) begin
                        r_x    <= sect_y;
                        r_sec  <= r_sec + SW'(1);
                        r_ld   <= '0;
                        r_term <= '0;
                    end
                end
                ST_GAIN: r_gain_phase <= 1'b1;
                ST_OUT: begin
                    if (out_free) begin
                        r_gain_phase <= 1'b0;
                        r_busy       <= 1'b0;
                        if (mul_p > OUT_ONE) begin
                            r_out_sample <= 16'sd32767;
                            r_out_clip   <= 1'b1;
                        end else if (mul_p < -OUT_ONE) begin
                            r_out_sample <= -16'sd32767;
                            r_out_clip   <= 1'b1;
                        end else begin
                            r_out_sample <= p_neg ? -16'(q_mag) : 16'(q_mag);
                            r_out_clip   <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_clipped    = r_out_clip;
endmodule

// File: test/tb_biquad_cascade_equalizer.sv
// Testbench for the biquad cascade equalizer: directed and random samples and
// coefficient writes, checked against a predictor of the filter. Needs bqeq_pkg.
module tb_biquad_cascade_equalizer;
    timeunit 1ns;
    timeprecision 1ps;

    import bqeq_pkg::*;

    localparam int NSEC    = 5;
    localparam int NCOEF   = NSEC * 5;
    localparam int NHIST   = NSEC * 4;
    localparam int FRAC    = 30;
    localparam longint UNITY_Q41 = longint'(1) << 41;

    typedef struct {
        t_req               kind;
        logic signed [15:0] sample;
        logic [4:0]         slot;
        logic signed [31:0] coef;
    } t_word;

    typedef struct {
        logic signed [15:0] sample;
        logic               clip;
    } t_eq_out;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_req_type = 1'b0;
    logic signed [15:0] i_sample_in = '0;
    logic [4:0]         i_coef_index = '0;
    logic signed [31:0] i_coef_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_sample_out;
    logic               o_clipped;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = 1'b0;
    logic [31:0]        i_cfg_data = '0;

    biquad_cascade_equalizer u_top (.*);

    always #10 i_clk = ~i_clk;

    // Predictor state: its own copy of the coefficients, history and registers.
    logic signed [31:0] coef_mem [NCOEF];
    logic signed [31:0] hist_mem [NHIST];
    logic [15:0]        gain_reg;
    logic               enable_reg;

    t_word   pending_words [$];
    t_eq_out expected_out  [$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      n_samples = 0;
    int      n_coefs = 0;
    int      n_clipped = 0;

    task automatic report(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (at %0t)", what, got, want, $realtime);
    endtask

    function automatic logic signed [31:0] run_biquad(int s, logic signed [31:0] x);
        longint acc;
        longint rnd;
        int     c;
        int     h;
        c   = s * 5;
        h   = s * 4;
        acc = 0;
        acc += (longint'(coef_mem[c])     * longint'(x))             >>> 2;
        acc += (longint'(coef_mem[c + 1]) * longint'(hist_mem[h]))     >>> 2;
        acc += (longint'(coef_mem[c + 2]) * longint'(hist_mem[h + 1])) >>> 2;
        acc += (longint'(coef_mem[c + 3]) * longint'(hist_mem[h + 2])) >>> 2;
        acc += (longint'(coef_mem[c + 4]) * longint'(hist_mem[h + 3])) >>> 2;
        // Round half up by the remaining fraction bits, then saturate to Q4.27.
        rnd = (acc + (longint'(1) << (FRAC - 3))) >>> (FRAC - 2);
        if (rnd > 64'sd2147483647) rnd = 64'sd2147483647;
        if (rnd < -64'sd2147483648) rnd = -64'sd2147483648;
        hist_mem[h + 1] = hist_mem[h];
        hist_mem[h]     = x;
        hist_mem[h + 3] = hist_mem[h + 2];
        hist_mem[h + 2] = rnd[31:0];
        return rnd[31:0];
    endfunction

    // Applies one accepted word to the predictor and queues any result it causes.
    task automatic equalize(t_word w);
        logic signed [31:0] sig;
        longint  p;
        longint  mag;
        longint  q;
        longint  g;
        t_eq_out r;
        if (w.kind == REQ_COEF) begin
            n_coefs++;
            if (w.slot < NCOEF) coef_mem[w.slot] = w.coef;
            return;
        end
        n_samples++;
        r.clip = 1'b0;
        if (!enable_reg) begin
            r.sample = w.sample;
        end else begin
            sig = 32'(longint'(w.sample) * 4096);
            for (int s = 0; s < NSEC; s++) sig = run_biquad(s, sig);
            g = (gain_reg > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(gain_reg);
            p = longint'(sig) * g;
            if (p > UNITY_Q41) begin
                r.sample = 16'sd32767;
                r.clip   = 1'b1;
            end else if (p < -UNITY_Q41) begin
                r.sample = -16'sd32767;
                r.clip   = 1'b1;
            end else begin
                mag = (p < 0) ? -p : p;
                q   = (mag * 32767) >>> 41;
                r.sample = 16'((p < 0) ? -q : q);
            end
        end
        if (r.clip) n_clipped++;
        expected_out.push_back(r);
    endtask

    // Driver: offers the next pending word, idling at random between words.
    always @(posedge i_clk) begin
        t_word w;
        logic  next_valid;
        next_valid = i_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                w.kind   = t_req'(i_req_type);
                w.sample = i_sample_in;
                w.slot   = i_coef_index;
                w.coef   = i_coef_value;
                equalize(w);
                next_valid = 1'b0;
            end
            if (!next_valid && pending_words.size() > 0
                    && $urandom_range(99) >= send_idle_pct) begin
                w = pending_words.pop_front();
                i_req_type   <= w.kind;
                i_sample_in  <= w.sample;
                i_coef_index <= w.slot;
                i_coef_value <= w.coef;
                next_valid   = 1'b1;
            end
        end
        i_valid <= next_valid;
    end

    // Monitor: stalls the result side at random and checks every word taken.
    always @(posedge i_clk) begin
        t_eq_out e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_out.size() == 0) begin
                report("unexpected result", o_sample_out, 0);
            end else begin
                e = expected_out.pop_front();
                if (o_sample_out !== e.sample) report("sample_out", o_sample_out, e.sample);
                if (o_clipped !== e.clip) report("clipped", o_clipped, e.clip);
            end
        end
        i_ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_VOLUME_GAIN) gain_reg = data[15:0];
        else enable_reg = data[0];
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until the block has drained: nothing left to send, no word on offer
    // and every expected result taken. Values are looked at between edges.
    task automatic drain();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_valid || expected_out.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic t_word sample_word(logic signed [15:0] v);
        t_word w;
        w.kind   = REQ_SAMPLE;
        w.sample = v;
        w.slot   = 5'($urandom);
        w.coef   = 32'($urandom);
        return w;
    endfunction

    function automatic t_word coef_word(int slot, logic signed [31:0] v);
        t_word w;
        w.kind   = REQ_COEF;
        w.sample = 16'($urandom);
        w.slot   = 5'(slot);
        w.coef   = v;
        return w;
    endfunction

    // Random traffic: mostly audio words with the odd coefficient reload of a
    // whole section, plus a little noise (full-range values, unused slots).
    task automatic queue_random(int count);
        int s;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 88) begin
                pending_words.push_back(sample_word(16'($urandom)));
            end else if ($urandom_range(3) != 0) begin
                s = $urandom_range(NSEC - 1);
                pending_words.push_back(coef_word(s * 5,     $signed($urandom) >>> 2));
                pending_words.push_back(coef_word(s * 5 + 1, $signed($urandom) >>> 3));
                pending_words.push_back(coef_word(s * 5 + 2, $signed($urandom) >>> 3));
                pending_words.push_back(coef_word(s * 5 + 3, $signed($urandom) >>> 2));
                pending_words.push_back(coef_word(s * 5 + 4, $signed($urandom) >>> 3));
                n += 4;
            end else begin
                pending_words.push_back(coef_word($urandom_range(31), 32'($urandom)));
            end
        end
    endtask

    initial begin
        int gains [6] = '{16384, 65535, 0, 20000, 32768, 0};
        int ens   [6] = '{1, 1, 1, 0, 1, 1};
        int sidle [6] = '{0, 68, 0, 31, 0, 68};
        int rstl  [6] = '{0, 0, 68, 31, 31, 68};
        int cnt   [6] = '{300, 300, 300, 300, 300, 300};

        for (int i = 0; i < NCOEF; i++) coef_mem[i] = (i % 5 == 0) ? 32'sh4000_0000 : '0;
        for (int i = 0; i < NHIST; i++) hist_mem[i] = '0;
        gain_reg   = GAIN_RESET;
        enable_reg = 1'b1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset settings: passthrough coefficients, full-scale
        // samples, extreme coefficients, writes to slots past the last section.
        pending_words.push_back(sample_word(16'sh7FFF));
        pending_words.push_back(sample_word(-16'sh8000));
        pending_words.push_back(sample_word(16'sd0));
        pending_words.push_back(sample_word(-16'sd1));
        pending_words.push_back(coef_word(25, 32'sh7FFF_FFFF));
        pending_words.push_back(coef_word(31, -32'sh8000_0000));
        pending_words.push_back(sample_word(16'sd12345));
        pending_words.push_back(coef_word(0, 32'sh7FFF_FFFF));
        pending_words.push_back(coef_word(24, -32'sh8000_0000));
        pending_words.push_back(sample_word(16'sh7FFF));
        pending_words.push_back(sample_word(-16'sh8000));
        pending_words.push_back(sample_word(16'sd1000));
        pending_words.push_back(coef_word(0, 32'sh4000_0000));
        pending_words.push_back(coef_word(24, '0));
        pending_words.push_back(coef_word(3, 32'sh2000_0000));
        pending_words.push_back(sample_word(16'sd20000));
        pending_words.push_back(sample_word(-16'sd20000));
        pending_words.push_back(coef_word(3, '0));
        drain();

        // Gain above two and disabled passthrough on extremes.
        write_reg(CFG_VOLUME_GAIN, 32'hFFFF_FFFF);
        write_reg(CFG_FILTER_ENABLE, 32'hFFFF_FFFE);
        pending_words.push_back(sample_word(16'sh7FFF));
        pending_words.push_back(sample_word(-16'sh8000));
        drain();
        write_reg(CFG_FILTER_ENABLE, 32'd1);
        pending_words.push_back(sample_word(16'sh7FFF));
        pending_words.push_back(sample_word(-16'sh8000));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct  = sidle[ph];
            recv_stall_pct = rstl[ph];
            write_reg(CFG_VOLUME_GAIN,
                      (ph == 5) ? {16'($urandom), 16'($urandom_range(32768))} : gains[ph]);
            write_reg(CFG_FILTER_ENABLE, ens[ph]);
            if (ph == 0) begin
                // The sender holds back until every queued result is back.
                queue_random(cnt[ph] / 2);
                drain();
                queue_random(cnt[ph] - cnt[ph] / 2);
            end else begin
                queue_random(cnt[ph]);
            end
            drain();
        end

        $display("ran %0d audio words (%0d clipped) and %0d coefficient writes",
                 n_samples, n_clipped, n_coefs);
        $display("over gains from zero past two, filter on and off, and six send and stall mixes");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #400ms;
        $display("timeout with %0d results outstanding", expected_out.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: biquad_cascade_equalizer.f
hw/rtl/bqeq_pkg.sv
hw/rtl/bqeq_mul.sv
hw/rtl/biquad_cascade_equalizer.sv
test/tb_biquad_cascade_equalizer.sv
